// File: rtl/core/gsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gsg_pkg
// Shared types and constants of the Gaussian sample generator: sequencer
// states, fixed-point constants and the Horner divisor and reciprocal tables.
// ----------------------------------------------------------------------------
package gsg_pkg;

   localparam int unsigned RAD_W       = 20;
   localparam int unsigned LOG_W       = 35;
   localparam logic [21:0] RADIUS_LIMIT = 22'd1000000;
   localparam logic signed [11:0] DRAW_OFFSET = 12'sd1000;
   localparam logic [31:0] LN2_Q30     = 32'd744261118;
   localparam logic [31:0] PI_Q30      = 32'hC90F_DAA2;
   localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
   localparam logic [2:0]  HORNER_LAST = 3'd5;

   // phase = r2 * 2^32 / 10^6 = r2 * 2^26 / 15625; reciprocal is 2^45 / 15625
   localparam logic [13:0] PH_DIVISOR  = 14'd15625;
   localparam logic [31:0] PH_RECIP    = 32'd2251799813;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOG_SQ,
      S_LOG_UPD,
      S_V_MUL,
      S_V_UPD,
      S_SQRT,
      S_PH_MUL,
      S_PH_EST,
      S_PH_CMUL,
      S_PH_FIX,
      S_ANG_MUL,
      S_ANG_UPD,
      S_X2_MUL,
      S_X2_UPD,
      S_H_MUL,
      S_H_LOAD,
      S_H_RMUL,
      S_H_EST,
      S_H_CMUL,
      S_H_UPD,
      S_C_MUL,
      S_C_FIX,
      S_P_MUL,
      S_P_RND,
      S_EMIT
   } gsg_state_type;

   // Q30 base-2 log: integer part from the top set bit, fraction by squaring
   function automatic logic [LOG_W-1:0] log2_q30_const(input logic [RAD_W-1:0] n);
      logic [4:0]  e;
      logic [63:0] m;
      logic [29:0] frac;
      e    = '0;
      frac = '0;
      for (int b = 0; b < RAD_W; b++) begin
         if (n[b]) e = 5'(b);
      end
      m = 64'(n) << (5'd30 - e);
      for (int i = 0; i < 30; i++) begin
         m    = (m * m) >> 30;
         frac = {frac[28:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            m       = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return {e, frac};
   endfunction

   localparam logic [LOG_W-1:0] LOG2_LIMIT = log2_q30_const(20'd1000000);

   // Taylor divisors in Horner order
   function automatic logic [7:0] horner_div(input logic use_sin, input logic [2:0] step);
      logic [7:0] k;
      k = 8'd2;
      unique case ({use_sin, step})
         4'b0_000: k = 8'd132;
         4'b0_001: k = 8'd90;
         4'b0_010: k = 8'd56;
         4'b0_011: k = 8'd30;
         4'b0_100: k = 8'd12;
         4'b0_101: k = 8'd2;
         4'b1_000: k = 8'd156;
         4'b1_001: k = 8'd110;
         4'b1_010: k = 8'd72;
         4'b1_011: k = 8'd42;
         4'b1_100: k = 8'd20;
         4'b1_101: k = 8'd6;
         default:  k = 8'd2;
      endcase
      return k;
   endfunction

   // floor(2^32 / k) for each Taylor divisor; the estimate is low by at most one
   function automatic logic [31:0] horner_recip(input logic use_sin, input logic [2:0] step);
      logic [31:0] m;
      m = 32'd2147483648;
      unique case ({use_sin, step})
         4'b0_000: m = 32'd32537631;
         4'b0_001: m = 32'd47721858;
         4'b0_010: m = 32'd76695844;
         4'b0_011: m = 32'd143165576;
         4'b0_100: m = 32'd357913941;
         4'b0_101: m = 32'd2147483648;
         4'b1_000: m = 32'd27531841;
         4'b1_001: m = 32'd39045157;
         4'b1_010: m = 32'd59652323;
         4'b1_011: m = 32'd102261126;
         4'b1_100: m = 32'd214748364;
         4'b1_101: m = 32'd715827882;
         default:  m = 32'd2147483648;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/gaussian_sample_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_sample_generator
// Box-Muller style normal sample generator on one shared multiplier.
// ----------------------------------------------------------------------------
// Each request item brings two raw draws (0..1999). The block offsets them by
// 1000, forms the squared radius in millionths and drops the item when that
// radius is zero or at least one million. An accepted item with no radius
// held is stored. The next accepted item completes the pair and starts a
// sequencer that computes sqrt(-2 ln r1) * cos(2 pi r2) as signed fixed
// point with OUTPUT_FRAC_BITS fraction bits, rounded and saturated. That
// run keeps the request side busy and uses one 32x32 multiplier with a
// registered product: a 30-pass squaring log (square, then update), a
// 32-step square root, the phase division by a constant as a reciprocal
// multiply with a remainder fix, six Horner steps (reciprocal multiply,
// remainder fix), then cosine select, product, rounding and emit. The
// request side is ready only while the sequencer is idle; a finished
// sample sits in the response register while new items are taken, and the
// sequencer holds in its emit state while that register is still full and
// not being read.
// ----------------------------------------------------------------------------
module gaussian_sample_generator #(
   parameter int unsigned OUTPUT_FRAC_BITS = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [10:0]         req_draw_x,
   input  wire logic [10:0]         req_draw_y,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [15:0]       rsp_gaussian_value
);
   import gsg_pkg::*;

   localparam int unsigned RND_SH = 58 - OUTPUT_FRAC_BITS;
   localparam logic [63:0] RND_HALF = 64'd1 << (RND_SH - 1);

   gsg_state_type state_ff, state_in;

   logic                have_first_ff;
   logic [RAD_W-1:0]    first_radius_ff;
   logic [RAD_W-1:0]    second_radius_ff;
   logic [4:0]          cnt_ff;
   logic [2:0]          step_ff;
   logic [4:0]          exp_ff;
   logic [30:0]         m_ff;
   logic [29:0]         frac_ff;
   logic [63:0]         prod_ff;
   logic [63:0]         sq_rem_ff;
   logic [63:0]         sq_res_ff;
   logic [31:0]         qe_ff;
   logic [31:0]         hx_ff;
   logic [1:0]          quad_ff;
   logic [31:0]         a_ff;
   logic [31:0]         x2_ff;
   logic signed [33:0]  t_ff;
   logic signed [33:0]  c_ff;
   logic [15:0]         result_ff;
   logic                rsp_valid_ff;
   logic [15:0]         rsp_data_ff;

   // radius of the incoming pair
   logic signed [11:0]  dx, dy;
   logic signed [23:0]  sq_x, sq_y;
   logic [21:0]         rad;
   logic                rad_ok;

   assign dx     = $signed({1'b0, req_draw_x}) - DRAW_OFFSET;
   assign dy     = $signed({1'b0, req_draw_y}) - DRAW_OFFSET;
   assign sq_x   = dx * dx;
   assign sq_y   = dy * dy;
   assign rad    = 22'(unsigned'(sq_x)) + 22'(unsigned'(sq_y));
   assign rad_ok = (rad != 22'd0) && (rad < RADIUS_LIMIT);

   // top set bit of the held radius
   logic [4:0] r1_exp;
   always_comb begin
      r1_exp = '0;
      for (int b = 0; b < RAD_W; b++) begin
         if (first_radius_ff[b]) r1_exp = 5'(b);
      end
   end

   // log difference, clamped at zero
   logic [LOG_W-1:0] log_r1, log_diff;
   assign log_r1   = {exp_ff, frac_ff};
   assign log_diff = (LOG2_LIMIT > log_r1) ? (LOG2_LIMIT - log_r1) : '0;

   // square root step
   logic [63:0] sq_bit, sq_trial;
   assign sq_bit   = 64'd1 << {cnt_ff, 1'b0};
   assign sq_trial = sq_res_ff + sq_bit;

   // phase quotient: the reciprocal estimate is low by at most two
   logic [45:0] ph_rem;
   logic [31:0] ph_quo;
   assign ph_rem = {second_radius_ff, 26'b0} - prod_ff[45:0];
   always_comb begin
      if (ph_rem >= {31'b0, PH_DIVISOR, 1'b0}) ph_quo = qe_ff + 32'd2;
      else if (ph_rem >= {32'b0, PH_DIVISOR})  ph_quo = qe_ff + 32'd1;
      else                                     ph_quo = qe_ff;
   end

   // magnitudes and signs for the multiplier
   logic [31:0] t_mag, c_mag;
   assign t_mag = t_ff[33] ? 32'(-t_ff) : 32'(t_ff);
   assign c_mag = c_ff[33] ? 32'(-c_ff) : 32'(c_ff);

   logic use_sin;
   assign use_sin = quad_ff[0];

   // Horner quotient: the reciprocal estimate is low by at most one
   logic [7:0]  h_k;
   logic [31:0] h_recip, h_rem, h_quo;
   assign h_k     = horner_div(use_sin, step_ff);
   assign h_recip = horner_recip(use_sin, step_ff);
   assign h_rem   = hx_ff - prod_ff[31:0];
   assign h_quo   = (h_rem >= {24'b0, h_k}) ? (qe_ff + 32'd1) : qe_ff;

   // Horner update from the quotient
   logic signed [33:0] quo_signed, t_next;
   assign quo_signed = t_ff[33] ? -$signed({2'b0, h_quo}) : $signed({2'b0, h_quo});
   assign t_next     = ONE_Q30 - quo_signed;

   // cosine / sine select, quadrant sign and clamp
   logic signed [33:0] sin_mag, c_raw, c_quad, c_clamp;
   assign sin_mag = $signed(prod_ff[63:30]);
   always_comb begin
      if (use_sin) c_raw = t_ff[33] ? -sin_mag : sin_mag;
      else         c_raw = t_ff;
      c_quad = (quad_ff[1] ^ quad_ff[0]) ? -c_raw : c_raw;
      if (c_quad > ONE_Q30)       c_clamp = ONE_Q30;
      else if (c_quad < -ONE_Q30) c_clamp = -ONE_Q30;
      else                        c_clamp = c_quad;
   end

   // round to nearest, ties away from zero, then saturate
   logic [63:0] rnd_mag;
   logic [15:0] rnd_val;
   assign rnd_mag = (prod_ff + RND_HALF) >> RND_SH;
   always_comb begin
      if (c_ff[33]) begin
         rnd_val = (rnd_mag > 64'd32768) ? 16'h8000 : 16'(16'd0 - 16'(rnd_mag));
      end else begin
         rnd_val = (rnd_mag > 64'd32767) ? 16'h7FFF : 16'(rnd_mag);
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid && rad_ok && have_first_ff) state_in = S_LOG_SQ;
         S_LOG_SQ:  state_in = S_LOG_UPD;
         S_LOG_UPD: state_in = (cnt_ff == 5'd0) ? S_V_MUL : S_LOG_SQ;
         S_V_MUL:   state_in = S_V_UPD;
         S_V_UPD:   state_in = S_SQRT;
         S_SQRT:    if (cnt_ff == 5'd0) state_in = S_PH_MUL;
         S_PH_MUL:  state_in = S_PH_EST;
         S_PH_EST:  state_in = S_PH_CMUL;
         S_PH_CMUL: state_in = S_PH_FIX;
         S_PH_FIX:  state_in = S_ANG_MUL;
         S_ANG_MUL: state_in = S_ANG_UPD;
         S_ANG_UPD: state_in = S_X2_MUL;
         S_X2_MUL:  state_in = S_X2_UPD;
         S_X2_UPD:  state_in = S_H_MUL;
         S_H_MUL:   state_in = S_H_LOAD;
         S_H_LOAD:  state_in = S_H_RMUL;
         S_H_RMUL:  state_in = S_H_EST;
         S_H_EST:   state_in = S_H_CMUL;
         S_H_CMUL:  state_in = S_H_UPD;
         S_H_UPD:   state_in = (step_ff == HORNER_LAST) ? S_C_MUL : S_H_MUL;
         S_C_MUL:   state_in = S_C_FIX;
         S_C_FIX:   state_in = S_P_MUL;
         S_P_MUL:   state_in = S_P_RND;
         S_P_RND:   state_in = S_EMIT;
         S_EMIT:    if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // sequencer outputs: handshake and multiplier operands
   logic [31:0] mul_a, mul_b;
   always_comb begin
      req_ready = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         S_IDLE:    req_ready = 1'b1;
         S_LOG_SQ:  begin mul_a = {1'b0, m_ff}; mul_b = {1'b0, m_ff}; end
         S_V_MUL:   begin mul_a = {5'b0, log_diff[34:8]}; mul_b = LN2_Q30; end
         S_PH_MUL:  begin mul_a = {12'b0, second_radius_ff}; mul_b = PH_RECIP; end
         S_PH_CMUL: begin mul_a = qe_ff; mul_b = {18'b0, PH_DIVISOR}; end
         S_ANG_MUL: begin mul_a = {2'b0, qe_ff[29:0]}; mul_b = PI_Q30; end
         S_X2_MUL:  begin mul_a = a_ff; mul_b = a_ff; end
         S_H_MUL:   begin mul_a = x2_ff; mul_b = t_mag; end
         S_H_RMUL:  begin mul_a = hx_ff; mul_b = h_recip; end
         S_H_CMUL:  begin mul_a = qe_ff; mul_b = {24'b0, h_k}; end
         S_C_MUL:   begin mul_a = a_ff; mul_b = t_mag; end
         S_P_MUL:   begin mul_a = sq_res_ff[31:0]; mul_b = c_mag; end
         default:   ;
      endcase
   end

   // shared multiplier, product registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         have_first_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && req_valid && rad_ok) begin
            have_first_ff <= !have_first_ff;
         end
         if (state_ff == S_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_radius_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && rad_ok) begin
                  if (!have_first_ff) begin
                     first_radius_ff <= rad[RAD_W-1:0];
                  end else begin
                     // start the log of the held radius
                     second_radius_ff <= rad[RAD_W-1:0];
                     exp_ff           <= r1_exp;
                     m_ff             <= 31'(first_radius_ff) << (5'd30 - r1_exp);
                     frac_ff          <= '0;
                     cnt_ff           <= 5'd29;
                  end
               end
            end
            S_LOG_UPD: begin
               frac_ff <= {frac_ff[28:0], prod_ff[61]};
               m_ff    <= prod_ff[61] ? prod_ff[61:31] : prod_ff[60:30];
               cnt_ff  <= cnt_ff - 5'd1;
            end
            S_V_UPD: begin
               // load the root
               sq_rem_ff <= {2'b0, prod_ff[56:21], 26'b0};
               sq_res_ff <= '0;
               cnt_ff    <= 5'd31;
            end
            S_SQRT: begin
               if (sq_rem_ff >= sq_trial) begin
                  sq_rem_ff <= sq_rem_ff - sq_trial;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               cnt_ff <= cnt_ff - 5'd1;
            end
            S_PH_EST:  qe_ff <= prod_ff[50:19];
            S_PH_FIX:  qe_ff <= ph_quo;
            S_ANG_MUL: quad_ff <= qe_ff[31:30];
            S_ANG_UPD: a_ff <= {1'b0, prod_ff[61:31]};
            S_X2_UPD: begin
               x2_ff   <= prod_ff[61:30];
               t_ff    <= ONE_Q30;
               step_ff <= '0;
            end
            S_H_LOAD:  hx_ff <= prod_ff[61:30];
            S_H_EST:   qe_ff <= prod_ff[63:32];
            S_H_UPD: begin
               t_ff    <= t_next;
               step_ff <= step_ff + 3'd1;
            end
            S_C_FIX: c_ff      <= c_clamp;
            S_P_RND: result_ff <= rnd_val;
            S_EMIT:  if (out_free) rsp_data_ff <= result_ff;
            default: ;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_gaussian_value = $signed(rsp_data_ff);

endmodule
`default_nettype wire
